// ----- rtl/rbst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants for the ray/box slab test
// Fixed-point format, divider widths and pipeline latency.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_W = 32;                 // coordinate width
  localparam int FRAC_W  = 16;                 // fractional bits
  localparam int NUM_W   = COORD_W + 1;        // |corner - origin| width
  localparam int QUOT_W  = NUM_W + FRAC_W;     // full quotient width, one stage per bit
  localparam int NUM_AX  = 3;
  localparam int LAT     = QUOT_W + 5;         // accept to valid_o, in cycles

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // per-axis sideband that rides along the divider pipeline
  typedef struct packed {
    logic par;      // direction component is zero
    logic in_slab;  // origin within slab
    logic neg_min;  // quotient for min corner is negative
    logic neg_max;  // quotient for max corner is negative
  } axis_side_t;

endpackage

// ----- rtl/rbst_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_div_pipe: pipelined unsigned restoring divider
// Computes (num << FRAC_W) / den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rbst_div_pipe
  import rbst_pkg::*;
(
  input  logic              clk_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [COORD_W-1:0] den_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [COORD_W-1:0] rem_q [QUOT_W];
  logic [COORD_W-1:0] den_q [QUOT_W];
  logic [QUOT_W-1:0]  dvd_q [QUOT_W];
  logic [QUOT_W-1:0]  quo_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [COORD_W-1:0] rem_in, den_in, rem_d;
    logic [QUOT_W-1:0]  dvd_in, quo_in;
    logic [COORD_W:0]   trial, diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign dvd_in = {num_i, {FRAC_W{1'b0}}};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = {rem_in, dvd_in[QUOT_W-1]};
      diff  = trial - {1'b0, den_in};
      ge    = trial >= {1'b0, den_in};
      // remainder stays below den, so it fits COORD_W bits
      rem_d = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      dvd_q[k] <= {dvd_in[QUOT_W-2:0], 1'b0};
      quo_q[k] <= {quo_in[QUOT_W-2:0], ge};
    end
  end

  assign quot_o = quo_q[QUOT_W-1];

endmodule

// ----- rtl/ray_box_slab_test_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit: ray versus axis-aligned box hit test
// Slab test on signed Q16.16 operands, fully pipelined.
// ----------------------------------------------------------------------------
// One item (ray origin, direction, box corners) is taken in every cycle; busy
// never rises. The hit flag appears on hit_o together with valid_o after the
// item passes the input prep stage, the six parallel dividers that produce
// one quotient bit per stage (49 stages), and the saturation, ordering, x/y
// narrowing and z test stages. Results cannot be held off, so the receiver
// must take valid_o whenever it is high.
module ray_box_slab_test_unit
  import rbst_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  coord_t origin_x_i,
  input  coord_t origin_y_i,
  input  coord_t origin_z_i,
  input  coord_t dir_x_i,
  input  coord_t dir_y_i,
  input  coord_t dir_z_i,
  input  coord_t box_min_x_i,
  input  coord_t box_min_y_i,
  input  coord_t box_min_z_i,
  input  coord_t box_max_x_i,
  input  coord_t box_max_y_i,
  input  coord_t box_max_z_i,
  output logic   valid_o,
  output logic   hit_o
);

  coord_t org [NUM_AX];
  coord_t dir [NUM_AX];
  coord_t bmn [NUM_AX];
  coord_t bmx [NUM_AX];

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};
  assign bmn = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign bmx = '{box_max_x_i, box_max_y_i, box_max_z_i};

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: magnitudes and signs
  logic                s1_vld_q;
  logic [NUM_W-1:0]    s1_nmin_q [NUM_AX];
  logic [NUM_W-1:0]    s1_nmax_q [NUM_AX];
  logic [COORD_W-1:0]  s1_den_q  [NUM_AX];
  axis_side_t          s1_side_q [NUM_AX];

  logic [QUOT_W-1:0]   q_min [NUM_AX];
  logic [QUOT_W-1:0]   q_max [NUM_AX];

  axis_side_t          dl_side_q [QUOT_W][NUM_AX];
  logic [QUOT_W-1:0]   dl_vld_q;

  // saturated t values
  logic   st_vld_q;
  coord_t st_tmin_q [NUM_AX];
  coord_t st_tmax_q [NUM_AX];
  axis_side_t st_side_q [NUM_AX];

  // ordered intervals
  logic   od_vld_q, od_miss_q;
  coord_t od_lo_q [NUM_AX];
  coord_t od_hi_q [NUM_AX];

  // x/y narrowed
  logic   xy_vld_q, xy_ok_q;
  coord_t xy_lo_q, xy_hi_q, xy_zlo_q, xy_zhi_q;

  logic   out_vld_q, out_hit_q;

  for (genvar a = 0; a < NUM_AX; a++) begin : g_axis
    logic signed [NUM_W-1:0] dmn_p, dmn_n, dmx_p, dmx_n;
    logic signed [NUM_W-1:0] dir_x, dir_n;
    axis_side_t side_d;
    coord_t tmin_d, tmax_d;

    always_comb begin
      dmn_p = NUM_W'(bmn[a]) - NUM_W'(org[a]);
      dmn_n = NUM_W'(org[a]) - NUM_W'(bmn[a]);
      dmx_p = NUM_W'(bmx[a]) - NUM_W'(org[a]);
      dmx_n = NUM_W'(org[a]) - NUM_W'(bmx[a]);
      dir_x = NUM_W'(dir[a]);
      dir_n = -dir_x;
      side_d.par     = dir[a] == '0;
      side_d.in_slab = (bmn[a] <= org[a]) && (org[a] <= bmx[a]);
      side_d.neg_min = (bmn[a] < org[a]) ^ dir[a][COORD_W-1];
      side_d.neg_max = (bmx[a] < org[a]) ^ dir[a][COORD_W-1];
    end

    always_ff @(posedge clk_i) begin
      s1_nmin_q[a] <= (bmn[a] < org[a]) ? dmn_n : dmn_p;
      s1_nmax_q[a] <= (bmx[a] < org[a]) ? dmx_n : dmx_p;
      // |dir| fits COORD_W bits, -2^31 included
      s1_den_q[a]  <= dir[a][COORD_W-1] ? dir_n[COORD_W-1:0] : dir_x[COORD_W-1:0];
      s1_side_q[a] <= side_d;
    end

    rbst_div_pipe u_div_min (
      .clk_i  (clk_i),
      .num_i  (s1_nmin_q[a]),
      .den_i  (s1_den_q[a]),
      .quot_o (q_min[a])
    );

    rbst_div_pipe u_div_max (
      .clk_i  (clk_i),
      .num_i  (s1_nmax_q[a]),
      .den_i  (s1_den_q[a]),
      .quot_o (q_max[a])
    );

    always_comb begin
      if (q_min[a][QUOT_W-1:COORD_W-1] != '0) begin
        tmin_d = dl_side_q[QUOT_W-1][a].neg_min ? T_MIN : T_MAX;
      end else begin
        tmin_d = dl_side_q[QUOT_W-1][a].neg_min ? -coord_t'(q_min[a][COORD_W-1:0])
                                                 : coord_t'(q_min[a][COORD_W-1:0]);
      end
      if (q_max[a][QUOT_W-1:COORD_W-1] != '0) begin
        tmax_d = dl_side_q[QUOT_W-1][a].neg_max ? T_MIN : T_MAX;
      end else begin
        tmax_d = dl_side_q[QUOT_W-1][a].neg_max ? -coord_t'(q_max[a][COORD_W-1:0])
                                                 : coord_t'(q_max[a][COORD_W-1:0]);
      end
    end

    always_ff @(posedge clk_i) begin
      st_tmin_q[a] <= tmin_d;
      st_tmax_q[a] <= tmax_d;
      st_side_q[a] <= dl_side_q[QUOT_W-1][a];
      // a parallel axis that passes leaves the interval open
      if (st_side_q[a].par) begin
        od_lo_q[a] <= T_MIN;
        od_hi_q[a] <= T_MAX;
      end else if (st_tmin_q[a] > st_tmax_q[a]) begin
        od_lo_q[a] <= st_tmax_q[a];
        od_hi_q[a] <= st_tmin_q[a];
      end else begin
        od_lo_q[a] <= st_tmin_q[a];
        od_hi_q[a] <= st_tmax_q[a];
      end
    end
  end

  // sideband delay matching the divider depth
  always_ff @(posedge clk_i) begin
    dl_side_q[0] <= s1_side_q;
    for (int k = 1; k < QUOT_W; k++) begin
      dl_side_q[k] <= dl_side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    od_miss_q <= (st_side_q[0].par && !st_side_q[0].in_slab)
              || (st_side_q[1].par && !st_side_q[1].in_slab)
              || (st_side_q[2].par && !st_side_q[2].in_slab);
    xy_ok_q   <= !od_miss_q && (od_lo_q[0] <= od_hi_q[1]) && (od_lo_q[1] <= od_hi_q[0]);
    xy_lo_q   <= (od_lo_q[1] > od_lo_q[0]) ? od_lo_q[1] : od_lo_q[0];
    xy_hi_q   <= (od_hi_q[1] < od_hi_q[0]) ? od_hi_q[1] : od_hi_q[0];
    xy_zlo_q  <= od_lo_q[2];
    xy_zhi_q  <= od_hi_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      dl_vld_q  <= '0;
      st_vld_q  <= 1'b0;
      od_vld_q  <= 1'b0;
      xy_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_hit_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      dl_vld_q  <= {dl_vld_q[QUOT_W-2:0], s1_vld_q};
      st_vld_q  <= dl_vld_q[QUOT_W-1];
      od_vld_q  <= st_vld_q;
      xy_vld_q  <= od_vld_q;
      out_vld_q <= xy_vld_q;
      out_hit_q <= xy_vld_q && xy_ok_q && (xy_lo_q <= xy_zhi_q) && (xy_zlo_q <= xy_hi_q);
    end
  end

  assign valid_o = out_vld_q;
  assign hit_o   = out_hit_q;

  // every result traces back to an accepted item
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result without matching item");

  a_keep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept, LAT) |-> valid_o)
    else $error("item lost in pipeline");

  a_hit_gated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> valid_o)
    else $error("hit flag outside result cycle");

endmodule
